[hw/rtl/dual_quotient_oscillator_defines.svh]
// Assertion macros for the dual quotient oscillator.
// No dependencies; included by the RTL files that carry assertions.
`ifndef DUAL_QUOTIENT_OSCILLATOR_DEFINES_SVH
`define DUAL_QUOTIENT_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define DQO_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dual_quotient_oscillator: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define DQO_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dual_quotient_oscillator: next-cycle check failed");

`endif

[hw/rtl/dqo_pkg.sv]
// Shared types, widths and fixed-point constants of the dual quotient oscillator.
// No dependencies.
`timescale 1ns / 1ps

package dqo_pkg;

  localparam int A_W   = 50;  // multiplicand (sample-side operand)
  localparam int B_W   = 35;  // coefficient operand
  localparam int M_W   = 26;  // multiplicand chunk fed to the multiplier
  localparam int P_W   = M_W + B_W;
  localparam int ACC_W = 86;
  localparam int SUM_W = 58;
  localparam int HW    = 48;  // filter value width
  localparam int DVD_W = 55;
  localparam int REM_W = 50;
  localparam int DEN_W = 34;
  localparam int NUM_W = 33;
  localparam int CNT_W = 6;
  localparam int Q_W   = DVD_W + 2;

  localparam logic signed [B_W-1:0] HP_A      = 35'sd1027579933;
  localparam logic signed [B_W-1:0] HP_B      = 35'sd2054145658;
  localparam logic signed [B_W-1:0] HP_C      = 35'sd982432250;
  localparam logic signed [B_W-1:0] DECAY_Q30 = 35'sd1064078148;
  localparam logic signed [B_W-1:0] ONE_Q30   = 35'sd1073741824;
  localparam logic [21:0]           SCALE_60  = 22'd3932160;
  localparam logic signed [Q_W-1:0] OFFSET_50 = 57'sd3276800;
  localparam logic signed [SUM_W-1:0] LIM48   = 58'sd140737488355327;

  localparam logic [CNT_W-1:0] RATIO_STEPS = 6'd31;
  localparam logic [CNT_W-1:0] QUOT_STEPS  = 6'd55;

  localparam logic [2:0] CFG_S1C2 = 3'd0;
  localparam logic [2:0] CFG_S1C3 = 3'd1;
  localparam logic [2:0] CFG_S2C2 = 3'd2;
  localparam logic [2:0] CFG_S2C3 = 3'd3;
  localparam logic [2:0] CFG_K1   = 3'd4;
  localparam logic [2:0] CFG_K2   = 3'd5;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MLO  = 8'b0000_0010,
    ST_MHI  = 8'b0000_0100,
    ST_RND  = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_DFIN = 8'b0010_0000,
    ST_QSET = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_HPA, OP_HPB, OP_HPC, OP_S1, OP_S2, OP_S3, OP_DEC, OP_KX
  } op_t;

  function automatic logic signed [HW-1:0] sat48(input logic signed [SUM_W-1:0] v);
    if (v > LIM48) begin
      return HW'(LIM48);
    end else if (v < -LIM48) begin
      return HW'(-LIM48);
    end else begin
      return HW'(v);
    end
  endfunction

endpackage

[hw/rtl/dual_quotient_oscillator.sv]
// An accepted price item runs to its result before the next is taken (in_ready is high only
// in idle), sooner when a peak or a quotient denominator is zero; priming items only update
// the price history. The shared 26x35 multiplier forms each product in states MLO, MHI and
// RND; the one-bit-per-cycle divider takes 31 and 55 steps per path.
// Reset: rst_n is synchronous, active low; it clears filter state, configuration and control.
// Top level of the dual quotient oscillator; uses dqo_pkg and the assertion header.
`timescale 1ns / 1ps
`include "dual_quotient_oscillator_defines.svh"

module dual_quotient_oscillator
  import dqo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_price,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_slow_oscillator,
  output logic signed [31:0] out_fast_oscillator,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  // The datapath is one multiplier, one rounding accumulator and one restoring divider,
  // stepped by a small sequencer. Each product a*b is formed in two halves of a (low 25
  // bits unsigned, then the signed high part shifted up), rounded half up and added to or
  // subtracted from a running sum. The high-pass filter takes three products. Each path
  // then takes three smoother products, a peak decay product, a 31-step ratio division, the
  // K*X product, a 55-step quotient division (none on a zero divisor). Paths share all units.

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   path_r, path_nxt;
  logic [1:0] seen_r, seen_nxt;

  logic signed [31:0] c2_r [2];
  logic signed [31:0] c3_r [2];
  logic signed [31:0] k_r  [2];

  logic signed [31:0] ph0_r, ph0_nxt, ph1_r, ph1_nxt;
  logic signed [HW-1:0] hh0_r, hh0_nxt, hh1_r, hh1_nxt;
  logic signed [HW-1:0] sh0_r [2];
  logic signed [HW-1:0] sh1_r [2];
  logic signed [HW-1:0] sh0_nxt [2];
  logic signed [HW-1:0] sh1_nxt [2];
  logic [HW-1:0] peak_r [2];
  logic [HW-1:0] peak_nxt [2];

  logic signed [33:0]    d_r, d_nxt;
  logic signed [HW:0]    hsum_r, hsum_nxt;
  logic signed [HW-1:0]  filt_r, filt_nxt;
  logic signed [31:0]    x_r, x_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic signed [DEN_W-1:0] den_r, den_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [31:0] res_r [2];
  logic signed [31:0] res_nxt [2];

  logic               div_mode_r, div_mode_nxt;  // 1: ratio X, 0: final quotient
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [DVD_W-1:0]   quo_r, quo_nxt;
  logic [HW-1:0]      dsr_r, dsr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_slow_r, out_slow_nxt, out_fast_r, out_fast_nxt;

  // Operand selection for the shared multiplier.
  logic signed [A_W-1:0] op_a;
  logic signed [B_W-1:0] op_b;
  logic                  op_s31;
  logic                  op_sub;
  logic signed [B_W-1:0] c1;

  assign c1 = ONE_Q30 - B_W'(c2_r[path_r]) - B_W'(c3_r[path_r]);

  always_comb begin
    op_a   = A_W'(d_r);
    op_b   = HP_A;
    op_s31 = 1'b0;
    op_sub = 1'b0;
    unique case (op_r)
      OP_HPA: begin
        op_a = A_W'(d_r);
        op_b = HP_A;
      end
      OP_HPB: begin
        op_a = A_W'(hh0_r);
        op_b = HP_B;
      end
      OP_HPC: begin
        op_a   = A_W'(hh1_r);
        op_b   = HP_C;
        op_sub = 1'b1;
      end
      OP_S1: begin
        // The halving of the c1 term is folded into a 31-bit rounding shift.
        op_a   = A_W'(hsum_r);
        op_b   = c1;
        op_s31 = 1'b1;
      end
      OP_S2: begin
        op_a = A_W'(sh0_r[path_r]);
        op_b = B_W'(c2_r[path_r]);
      end
      OP_S3: begin
        op_a = A_W'(sh1_r[path_r]);
        op_b = B_W'(c3_r[path_r]);
      end
      OP_DEC: begin
        op_a = A_W'($signed({1'b0, peak_r[path_r]}));
        op_b = DECAY_Q30;
      end
      OP_KX: begin
        op_a = A_W'(k_r[path_r]);
        op_b = B_W'(x_r);
      end
      default: begin
        op_a = A_W'(d_r);
      end
    endcase
  end

  logic signed [M_W-1:0]   mul_a;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] rnd_full;
  logic signed [SUM_W-1:0] rnd;
  logic signed [SUM_W-1:0] sum_new;

  assign mul_a = (state_r == ST_MLO) ? $signed({1'b0, op_a[24:0]}) : $signed(op_a[49:25]);
  assign prod  = mul_a * op_b;

  assign rnd_full = op_s31 ? ((acc_r + (ACC_W'(1) <<< 30)) >>> 31)
                           : ((acc_r + (ACC_W'(1) <<< 29)) >>> 30);
  assign rnd      = SUM_W'(rnd_full);
  assign sum_new  = op_sub ? (sum_r - rnd) : (sum_r + rnd);

  // Divider step: ratio mode compares before shifting, quotient mode shifts in a dividend
  // bit first.
  logic [REM_W-1:0] dv_t;
  logic [REM_W:0]   dv_diff;
  logic             dv_ge;
  logic [REM_W-1:0] dv_rem;

  assign dv_t    = div_mode_r ? rem_r : {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
  assign dv_diff = {1'b0, dv_t} - {3'b000, dsr_r};
  assign dv_ge   = !dv_diff[REM_W];
  assign dv_rem  = dv_ge ? dv_diff[REM_W-1:0] : dv_t;

  // Helpers for the finishing states.
  logic signed [HW-1:0] filt_sat;
  logic [HW-1:0]        filt_mag;
  logic [HW-1:0]        pk_dec;
  logic [HW-1:0]        pk_new;
  logic [NUM_W-1:0]     num_mag;
  logic [DEN_W-1:0]     den_mag;
  logic signed [Q_W-1:0] q_signed;
  logic signed [Q_W-1:0] q_off;
  logic signed [31:0]   q_sat;
  logic signed [HW-1:0] hp_sat;
  logic [30:0]          x_mag;

  assign filt_sat = sat48(sum_new);
  assign hp_sat   = sat48(sum_new);
  assign filt_mag = filt_r[HW-1] ? HW'(-filt_r) : HW'(filt_r);
  assign pk_dec   = rnd[HW-1:0];
  assign pk_new   = (filt_mag > pk_dec) ? filt_mag : pk_dec;
  assign num_mag  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign den_mag  = den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
  assign x_mag    = quo_r[30:0];
  assign q_signed = (num_r[NUM_W-1] ^ den_r[DEN_W-1]) ? -$signed({2'b00, quo_r})
                                                       :  $signed({2'b00, quo_r});
  assign q_off    = q_signed + OFFSET_50;

  always_comb begin
    if (q_off > Q_W'(64'sd2147483647)) begin
      q_sat = 32'sh7FFF_FFFF;
    end else if (q_off < Q_W'(-64'sd2147483648)) begin
      q_sat = 32'sh8000_0000;
    end else begin
      q_sat = 32'(q_off);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    path_nxt      = path_r;
    seen_nxt      = seen_r;
    ph0_nxt       = ph0_r;
    ph1_nxt       = ph1_r;
    hh0_nxt       = hh0_r;
    hh1_nxt       = hh1_r;
    sh0_nxt       = sh0_r;
    sh1_nxt       = sh1_r;
    peak_nxt      = peak_r;
    d_nxt         = d_r;
    hsum_nxt      = hsum_r;
    filt_nxt      = filt_r;
    x_nxt         = x_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    div_mode_nxt  = div_mode_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    dsr_nxt       = dsr_r;
    out_valid_nxt = out_valid_r;
    out_slow_nxt  = out_slow_r;
    out_fast_nxt  = out_fast_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ph1_nxt = ph0_r;
          ph0_nxt = in_price;
          if (seen_r != 2'd2) begin
            // Priming item: history only, no result.
            seen_nxt = seen_r + 2'd1;
          end else begin
            d_nxt     = 34'(in_price) - (34'(ph0_r) <<< 1) + 34'(ph1_r);
            sum_nxt   = '0;
            op_nxt    = OP_HPA;
            path_nxt  = 1'b0;
            state_nxt = ST_MLO;
          end
        end
      end
      ST_MLO: begin
        acc_nxt   = ACC_W'(prod);
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        acc_nxt   = acc_r + (ACC_W'(prod) <<< 25);
        state_nxt = ST_RND;
      end
      ST_RND: begin
        state_nxt = ST_MLO;
        unique case (op_r)
          OP_HPA, OP_HPB, OP_S1, OP_S2: begin
            sum_nxt = sum_new;
            op_nxt  = op_t'(op_r + 3'd1);
          end
          OP_HPC: begin
            hh1_nxt  = hh0_r;
            hh0_nxt  = hp_sat;
            hsum_nxt = (HW+1)'(hp_sat) + (HW+1)'(hh0_r);
            sum_nxt  = '0;
            op_nxt   = OP_S1;
          end
          OP_S3: begin
            sh1_nxt[path_r] = sh0_r[path_r];
            sh0_nxt[path_r] = filt_sat;
            filt_nxt        = filt_sat;
            sum_nxt         = '0;
            op_nxt          = OP_DEC;
          end
          OP_DEC: begin
            peak_nxt[path_r] = pk_new;
            sum_nxt          = '0;
            if (pk_new == '0) begin
              x_nxt  = '0;
              op_nxt = OP_KX;
            end else begin
              div_mode_nxt = 1'b1;
              rem_nxt      = REM_W'(filt_mag);
              dsr_nxt      = pk_new;
              dvd_nxt      = '0;
              quo_nxt      = '0;
              cnt_nxt      = RATIO_STEPS;
              state_nxt    = ST_DIV;
            end
          end
          OP_KX: begin
            den_nxt   = DEN_W'(rnd) + DEN_W'(ONE_Q30);
            num_nxt   = NUM_W'(x_r) + NUM_W'(k_r[path_r]);
            state_nxt = ST_QSET;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_QSET: begin
        if (den_r == '0) begin
          // Zero denominator: saturate in the direction of the numerator.
          res_nxt[path_r] = num_r[NUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          if (!path_r) begin
            path_nxt  = 1'b1;
            op_nxt    = OP_S1;
            sum_nxt   = '0;
            state_nxt = ST_MLO;
          end else begin
            state_nxt = ST_OUT;
          end
        end else begin
          div_mode_nxt = 1'b0;
          rem_nxt      = '0;
          dvd_nxt      = DVD_W'(num_mag) * DVD_W'(SCALE_60);
          dsr_nxt      = HW'(den_mag);
          quo_nxt      = '0;
          cnt_nxt      = QUOT_STEPS;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_mode_r ? {dv_rem[REM_W-2:0], 1'b0} : dv_rem;
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        quo_nxt = {quo_r[DVD_W-2:0], dv_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_DFIN;
        end
      end
      ST_DFIN: begin
        if (div_mode_r) begin
          x_nxt     = filt_r[HW-1] ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
          op_nxt    = OP_KX;
          state_nxt = ST_MLO;
        end else begin
          res_nxt[path_r] = q_sat;
          if (!path_r) begin
            path_nxt  = 1'b1;
            op_nxt    = OP_S1;
            sum_nxt   = '0;
            state_nxt = ST_MLO;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        // Hand over once the output register is free; the next item may then enter.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_slow_nxt  = res_r[0];
          out_fast_nxt  = res_r[1];
          path_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_HPA;
      path_r      <= 1'b0;
      seen_r      <= '0;
      ph0_r       <= '0;
      ph1_r       <= '0;
      hh0_r       <= '0;
      hh1_r       <= '0;
      sh0_r       <= '{default: '0};
      sh1_r       <= '{default: '0};
      peak_r      <= '{default: '0};
      c2_r        <= '{default: '0};
      c3_r        <= '{default: '0};
      k_r         <= '{default: '0};
      div_mode_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      path_r      <= path_nxt;
      seen_r      <= seen_nxt;
      ph0_r       <= ph0_nxt;
      ph1_r       <= ph1_nxt;
      hh0_r       <= hh0_nxt;
      hh1_r       <= hh1_nxt;
      sh0_r       <= sh0_nxt;
      sh1_r       <= sh1_nxt;
      peak_r      <= peak_nxt;
      div_mode_r  <= div_mode_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_S1C2: c2_r[0] <= $signed(cfg_wdata);
          CFG_S1C3: c3_r[0] <= $signed(cfg_wdata);
          CFG_S2C2: c2_r[1] <= $signed(cfg_wdata);
          CFG_S2C3: c3_r[1] <= $signed(cfg_wdata);
          CFG_K1:   k_r[0]  <= $signed(cfg_wdata);
          CFG_K2:   k_r[1]  <= $signed(cfg_wdata);
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    hsum_r     <= hsum_nxt;
    filt_r     <= filt_nxt;
    x_r        <= x_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    acc_r      <= acc_nxt;
    sum_r      <= sum_nxt;
    res_r      <= res_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    dsr_r      <= dsr_nxt;
    out_slow_r <= out_slow_nxt;
    out_fast_r <= out_fast_nxt;
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_slow_oscillator = out_slow_r;
  assign out_fast_oscillator = out_fast_r;

  `DQO_ASSERT_SAME(a_div_count_live, clk, rst_n, state_r == ST_DIV, cnt_r != '0)
  `DQO_ASSERT_SAME(a_ratio_rem_bound, clk, rst_n, (state_r == ST_DIV) && div_mode_r,
                   rem_r <= {1'b0, dsr_r, 1'b0})
  `DQO_ASSERT_NEXT(a_primed_item_starts, clk, rst_n,
                   in_valid && in_ready && (seen_r == 2'd2), state_r == ST_MLO)
  `DQO_ASSERT_SAME(a_peak_in_range, clk, rst_n, 1'b1,
                   (peak_r[0] <= HW'(LIM48)) && (peak_r[1] <= HW'(LIM48)))

endmodule
